// File: rtl/assert_macros.svh
// assertion macros used by shake_envelope_generator
// clocked on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/seg_pkg.sv
// shared types, constants and helpers of the shake envelope generator
// used by seg_divider, seg_sqrt and shake_envelope_generator
package seg_pkg;

	localparam int DEF_CHANNELS = 2;
	localparam int DEF_ENV_POINTS = 5;
	localparam int NUM_REGS = 8;
	localparam int ADDR_W = 5;

	localparam logic [15:0] BIAS_XY = 16'd45875;
	localparam logic [16:0] NT_MAX = 17'h1FFFF;
	localparam logic [31:0] Q_ONE = 32'd65536;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ACCEL = 2'd1;
	localparam logic [1:0] MODE_FORCE = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [2:0] REG_ACCEL_LOW = 3'd0;
	localparam logic [2:0] REG_ACCEL_HIGH = 3'd1;
	localparam logic [2:0] REG_MAG_LOW = 3'd2;
	localparam logic [2:0] REG_MAG_HIGH = 3'd3;
	localparam logic [2:0] REG_DUR_LOW = 3'd4;
	localparam logic [2:0] REG_DUR_HIGH = 3'd5;
	localparam logic [2:0] REG_FORCE_DUR = 3'd6;
	localparam logic [2:0] REG_FREQ = 3'd7;

	localparam logic [30:0] CFG_RESET [NUM_REGS] = '{
		31'd6553600, 31'd39321600, 31'd6554, 31'd26214,
		31'd19661, 31'd45875, 31'd39322, 31'd769566
	};

	// envelope breakpoints, edit together with the point count
	localparam logic [16:0] ENV_TIME [16] = '{
		17'd0, 17'd6554, 17'd19661, 17'd32768, 17'd65536, 17'd0, 17'd0, 17'd0,
		17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
	};
	localparam logic [16:0] ENV_VALUE [16] = '{
		17'd65536, 17'd45875, 17'd32768, 17'd26214, 17'd0, 17'd0, 17'd0, 17'd0,
		17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
	};

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] root;
	} sqrt_rsp_t;

	function automatic logic env_oor(input logic [16:0] t, input int n);
		return (t < ENV_TIME[0]) || (t >= ENV_TIME[n-1]);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'h7FFFFFFF;
		if (v < -66'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	// negate with saturation
	function automatic logic [31:0] negsat(input logic signed [32:0] v);
		logic signed [33:0] n;
		n = -{v[32], v};
		if (n > 34'sd2147483647) return 32'h7FFFFFFF;
		if (n < -34'sd2147483648) return 32'h80000000;
		return n[31:0];
	endfunction

endpackage

// File: rtl/shake_envelope_generator.sv
// shake envelope generator: per-channel shake vectors with a piecewise-linear envelope
// a sequencer drives one shared multiplier, seg_divider and seg_sqrt
// depends on seg_pkg, seg_divider, seg_sqrt and assert_macros.svh
//
// usage: requests enter on s_t*, one result per request leaves on m_t*.
// s_tuser = {player, mode}, s_tdata = {vec_z, vec_y, vec_x, delta_time}.
// m_tuser = {active, out_player}, m_tdata = {shake_z, shake_y, shake_x}.
// write registers over the apb port only while no request is in flight (not enforced).
// s_tready is high only while the sequencer is idle; one request at a time.
// work per request after acceptance:
//   the result phase, plus a divide when the envelope segment is interpolated
//   tick: a divide per running channel, a check per stopped channel, then the result phase
//   acceleration event: a root, four divides and two envelope lookups
//   forced shake or clear: the result phase only
// the result waits in an output register; with m_tready low the next request is
// still accepted and runs until it has its own result to hand over.
// reset brings every channel to stopped with zero vector and 1.0 s duration,
// and the registers to their defaults; no clearing pass is needed.
`include "assert_macros.svh"

module shake_envelope_generator import seg_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int ENVELOPE_POINTS = DEF_ENV_POINTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [111:0]      s_tdata,  // delta_time, vec_x, vec_y, vec_z
	input  logic [2:0]        s_tuser,  // mode, player
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [95:0]       m_tdata,  // shake_x, shake_y, shake_z
	output logic [1:0]        m_tuser,  // out_player, active
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_TICK = 5'd1;
	localparam logic [4:0] S_TICK_W = 5'd2;
	localparam logic [4:0] S_AX = 5'd3;
	localparam logic [4:0] S_AY = 5'd4;
	localparam logic [4:0] S_AZ = 5'd5;
	localparam logic [4:0] S_SQ1 = 5'd6;
	localparam logic [4:0] S_SQ2 = 5'd7;
	localparam logic [4:0] S_SQ3 = 5'd8;
	localparam logic [4:0] S_SQRT_GO = 5'd9;
	localparam logic [4:0] S_SQRT_W = 5'd10;
	localparam logic [4:0] S_RATIO = 5'd11;
	localparam logic [4:0] S_RATIO_W = 5'd12;
	localparam logic [4:0] S_MAG = 5'd13;
	localparam logic [4:0] S_MAG2 = 5'd14;
	localparam logic [4:0] S_ENV = 5'd15;
	localparam logic [4:0] S_ENV_D = 5'd16;
	localparam logic [4:0] S_ENV_W = 5'd17;
	localparam logic [4:0] S_CMP = 5'd18;
	localparam logic [4:0] S_DUR = 5'd19;
	localparam logic [4:0] S_SMUL = 5'd20;
	localparam logic [4:0] S_SDIV = 5'd21;
	localparam logic [4:0] S_SDIV_W = 5'd22;
	localparam logic [4:0] S_START = 5'd23;
	localparam logic [4:0] S_OUT0 = 5'd24;
	localparam logic [4:0] S_OUT1 = 5'd25;
	localparam logic [4:0] S_OMUL = 5'd26;
	localparam logic [4:0] S_OCAP = 5'd27;
	localparam logic [4:0] S_PUSH = 5'd28;

	logic [4:0] st_q, ret_q;
	logic       player_q;
	logic [15:0] dt_q;
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic [CH_W-1:0] ch_q;
	logic [1:0] comp_q;

	logic [30:0] cfg_q [NUM_REGS];

	logic signed [31:0] stx_q [CHANNELS];
	logic signed [31:0] sty_q [CHANNELS];
	logic signed [31:0] stz_q [CHANNELS];
	logic [16:0] nt_q [CHANNELS];
	logic [31:0] rdur_q [CHANNELS];
	logic        run_q [CHANNELS];

	logic signed [31:0] ax_q, ay_q;
	logic [63:0] sq_q;
	logic [31:0] len_q;
	logic [16:0] ratio_q;
	logic signed [32:0] mag_q;
	logic [31:0] dur_q;
	logic signed [32:0] sv_q [3];
	logic        env_en_q;
	logic [3:0]  seg_q;
	logic        sign_q;
	logic [16:0] amp_q;
	logic [31:0] res_q [3];
	logic signed [65:0] mul_q;

	logic        m_tvalid_q;
	logic [95:0] mdata_q;
	logic [1:0]  muser_q;

	logic signed [32:0] mul_a, mul_b;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	logic        accept;
	logic        valid_ch;
	logic [16:0] t_w;
	logic        oor_w;
	logic [3:0]  seg_w;
	logic signed [17:0] dv_w;
	logic [63:0] mag_abs;
	logic [30:0] c_w;
	logic [63:0] tsum;
	logic [16:0] tnew;
	logic signed [32:0] acomp;
	logic signed [31:0] scomp;
	logic signed [18:0] amp_new;
	logic        cfg_wr;

	seg_divider u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	seg_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));

	assign accept = s_tvalid && s_tready;
	assign s_tready = (st_q == S_IDLE);
	assign valid_ch = (32'(player_q) < CHANNELS);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = {1'b0, cfg_q[paddr[4:2]]};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = mdata_q;
	assign m_tuser = muser_q;

	// envelope segment lookup for the current channel
	always_comb begin
		t_w = nt_q[ch_q];
		oor_w = env_oor(t_w, ENVELOPE_POINTS);
		seg_w = '0;
		for (int k = 0; k < 16; k++) begin
			if (k < ENVELOPE_POINTS && t_w >= ENV_TIME[k]) seg_w = 4'(k);
		end
		dv_w = $signed({1'b0, ENV_VALUE[seg_w + 4'd1]}) - $signed({1'b0, ENV_VALUE[seg_w]});
	end

	always_comb begin
		mag_abs = mul_q[65] ? 64'(-mul_q) : mul_q[63:0];
		c_w = (len_q > {1'b0, cfg_q[REG_ACCEL_HIGH]}) ? cfg_q[REG_ACCEL_HIGH] : len_q[30:0];
		tsum = {47'b0, nt_q[ch_q]} + div_rsp.quot;
		tnew = (tsum > {47'b0, NT_MAX}) ? NT_MAX : tsum[16:0];
		case (comp_q)
			2'd0: acomp = {ax_q[31], ax_q};
			2'd1: acomp = {ay_q[31], ay_q};
			default: acomp = {vz_q[31], vz_q};
		endcase
		case (comp_q)
			2'd0: scomp = stx_q[ch_q];
			2'd1: scomp = sty_q[ch_q];
			default: scomp = stz_q[ch_q];
		endcase
		amp_new = sign_q ? ($signed({2'b0, ENV_VALUE[seg_q]}) - $signed({1'b0, div_rsp.quot[17:0]}))
		                 : ($signed({2'b0, ENV_VALUE[seg_q]}) + $signed({1'b0, div_rsp.quot[17:0]}));
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			S_AX: begin
				mul_a = {vx_q[31], vx_q};
				mul_b = {17'b0, BIAS_XY};
			end
			S_AY: begin
				mul_a = {vy_q[31], vy_q};
				mul_b = {17'b0, BIAS_XY};
			end
			S_AZ: begin
				mul_a = {vz_q[31], vz_q};
				mul_b = {vz_q[31], vz_q};
			end
			S_SQ1: begin
				mul_a = {ax_q[31], ax_q};
				mul_b = {ax_q[31], ax_q};
			end
			S_SQ2: begin
				mul_a = {ay_q[31], ay_q};
				mul_b = {ay_q[31], ay_q};
			end
			S_MAG: begin
				mul_a = {16'b0, ratio_q};
				mul_b = $signed({2'b0, cfg_q[REG_MAG_HIGH]}) - $signed({2'b0, cfg_q[REG_MAG_LOW]});
			end
			S_CMP: begin
				mul_a = {16'b0, ratio_q};
				mul_b = $signed({2'b0, cfg_q[REG_DUR_HIGH]}) - $signed({2'b0, cfg_q[REG_DUR_LOW]});
			end
			S_ENV: begin
				mul_a = 33'(dv_w);
				mul_b = {16'b0, t_w - ENV_TIME[seg_w]};
			end
			S_SMUL: begin
				mul_a = acomp;
				mul_b = mag_q;
			end
			S_OUT0: begin
				mul_a = {16'b0, nt_q[ch_q]};
				mul_b = {2'b0, cfg_q[REG_FREQ]};
			end
			S_OMUL: begin
				mul_a = {scomp[31], scomp};
				mul_b = {16'b0, amp_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// divider and root requests
	always_comb begin
		div_req = '0;
		sqrt_req = '0;
		sqrt_req.start = (st_q == S_SQRT_GO);
		sqrt_req.radicand = sq_q;
		unique case (st_q)
			S_TICK: begin
				div_req.start = run_q[ch_q] && (rdur_q[ch_q] != '0);
				div_req.dividend = {32'b0, dt_q, 16'b0};
				div_req.divisor = rdur_q[ch_q];
			end
			S_RATIO: begin
				div_req.start = (len_q >= {1'b0, cfg_q[REG_ACCEL_LOW]}) &&
				                (cfg_q[REG_ACCEL_HIGH] > cfg_q[REG_ACCEL_LOW]);
				div_req.dividend = {17'b0, c_w - cfg_q[REG_ACCEL_LOW], 16'b0};
				div_req.divisor = {1'b0, cfg_q[REG_ACCEL_HIGH] - cfg_q[REG_ACCEL_LOW]};
			end
			S_ENV_D: begin
				div_req.start = 1'b1;
				div_req.dividend = mag_abs;
				div_req.divisor = {15'b0, ENV_TIME[seg_q + 4'd1] - ENV_TIME[seg_q]};
			end
			S_SDIV: begin
				div_req.start = 1'b1;
				div_req.dividend = mag_abs;
				div_req.divisor = len_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			ch_q <= '0;
			comp_q <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= CFG_RESET[i];
			for (int c = 0; c < CHANNELS; c++) begin
				stx_q[c] <= '0;
				sty_q[c] <= '0;
				stz_q[c] <= '0;
				nt_q[c] <= '0;
				rdur_q[c] <= Q_ONE;
				run_q[c] <= 1'b0;
			end
		end else begin
			if (cfg_wr) cfg_q[paddr[4:2]] <= pwdata[30:0];
			if (m_tvalid_q && m_tready && (st_q != S_PUSH)) m_tvalid_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						player_q <= s_tuser[2];
						dt_q <= s_tdata[15:0];
						vx_q <= s_tdata[47:16];
						vy_q <= s_tdata[79:48];
						vz_q <= s_tdata[111:80];
						ch_q <= CH_W'(s_tuser[2]);
						if (s_tuser[1:0] == MODE_TICK) begin
							ch_q <= '0;
							st_q <= S_TICK;
						end else if (s_tuser[1:0] == MODE_CLEAR) begin
							for (int c = 0; c < CHANNELS; c++) begin
								stx_q[c] <= '0;
								sty_q[c] <= '0;
								stz_q[c] <= '0;
								nt_q[c] <= '0;
								rdur_q[c] <= Q_ONE;
								run_q[c] <= 1'b0;
							end
							st_q <= S_OUT0;
						end else if (32'(s_tuser[2]) >= CHANNELS) begin
							st_q <= S_OUT0;
						end else if (s_tuser[1:0] == MODE_ACCEL) begin
							st_q <= S_AX;
						end else begin
							stx_q[CH_W'(s_tuser[2])] <= negsat({s_tdata[47], s_tdata[47:16]});
							sty_q[CH_W'(s_tuser[2])] <= negsat({s_tdata[79], s_tdata[79:48]});
							stz_q[CH_W'(s_tuser[2])] <= negsat({s_tdata[111], s_tdata[111:80]});
							nt_q[CH_W'(s_tuser[2])] <= '0;
							rdur_q[CH_W'(s_tuser[2])] <= {1'b0, cfg_q[REG_FORCE_DUR]};
							run_q[CH_W'(s_tuser[2])] <= 1'b1;
							st_q <= S_OUT0;
						end
					end
				end
				S_TICK: begin
					if (run_q[ch_q] && rdur_q[ch_q] != '0) begin
						st_q <= S_TICK_W;
					end else begin
						if (run_q[ch_q]) begin
							// zero duration ends the shake at once
							nt_q[ch_q] <= NT_MAX;
							run_q[ch_q] <= !env_oor(NT_MAX, ENVELOPE_POINTS);
						end
						if (32'(ch_q) == CHANNELS - 1) begin
							ch_q <= CH_W'(player_q);
							st_q <= S_OUT0;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				S_TICK_W: begin
					if (div_rsp.done) begin
						nt_q[ch_q] <= tnew;
						run_q[ch_q] <= !env_oor(tnew, ENVELOPE_POINTS);
						if (32'(ch_q) == CHANNELS - 1) begin
							ch_q <= CH_W'(player_q);
							st_q <= S_OUT0;
						end else begin
							ch_q <= ch_q + 1'b1;
							st_q <= S_TICK;
						end
					end
				end
				S_AX: st_q <= S_AY;
				S_AY: begin
					ax_q <= mul_q[47:16];
					st_q <= S_AZ;
				end
				S_AZ: begin
					ay_q <= mul_q[47:16];
					st_q <= S_SQ1;
				end
				S_SQ1: begin
					sq_q <= mul_q[63:0];
					st_q <= S_SQ2;
				end
				S_SQ2: begin
					sq_q <= sq_q + mul_q[63:0];
					st_q <= S_SQ3;
				end
				S_SQ3: begin
					sq_q <= sq_q + mul_q[63:0];
					st_q <= S_SQRT_GO;
				end
				S_SQRT_GO: st_q <= S_SQRT_W;
				S_SQRT_W: begin
					if (sqrt_rsp.done) begin
						len_q <= sqrt_rsp.root;
						st_q <= S_RATIO;
					end
				end
				S_RATIO: begin
					if (len_q < {1'b0, cfg_q[REG_ACCEL_LOW]}) begin
						st_q <= S_OUT0;
					end else if (cfg_q[REG_ACCEL_HIGH] <= cfg_q[REG_ACCEL_LOW]) begin
						ratio_q <= Q_ONE[16:0];
						st_q <= S_MAG;
					end else begin
						st_q <= S_RATIO_W;
					end
				end
				S_RATIO_W: begin
					if (div_rsp.done) begin
						ratio_q <= div_rsp.quot[16:0];
						st_q <= S_MAG;
					end
				end
				S_MAG: st_q <= S_MAG2;
				S_MAG2: begin
					mag_q <= $signed({2'b0, cfg_q[REG_MAG_LOW]}) + 33'(mul_q >>> 16);
					env_en_q <= run_q[ch_q];
					ret_q <= S_CMP;
					st_q <= S_ENV;
				end
				S_ENV: begin
					seg_q <= seg_w;
					if (!env_en_q || oor_w) begin
						amp_q <= '0;
						st_q <= ret_q;
					end else if (32'(seg_w) > ENVELOPE_POINTS - 2 ||
					             ENV_TIME[seg_w + 4'd1] == ENV_TIME[seg_w]) begin
						amp_q <= ENV_VALUE[seg_w];
						st_q <= ret_q;
					end else begin
						st_q <= S_ENV_D;
					end
				end
				S_ENV_D: begin
					sign_q <= mul_q[65];
					st_q <= S_ENV_W;
				end
				S_ENV_W: begin
					if (div_rsp.done) begin
						amp_q <= amp_new[16:0];
						st_q <= ret_q;
					end
				end
				S_CMP: begin
					if (mag_q <= $signed({16'b0, amp_q})) st_q <= S_OUT0;
					else st_q <= S_DUR;
				end
				S_DUR: begin
					dur_q <= 32'(cfg_q[REG_DUR_LOW]) + 32'(mul_q >>> 16);
					comp_q <= '0;
					if (len_q == '0) begin
						for (int k = 0; k < 3; k++) sv_q[k] <= '0;
						st_q <= S_START;
					end else begin
						st_q <= S_SMUL;
					end
				end
				S_SMUL: st_q <= S_SDIV;
				S_SDIV: begin
					sign_q <= mul_q[65];
					st_q <= S_SDIV_W;
				end
				S_SDIV_W: begin
					if (div_rsp.done) begin
						sv_q[comp_q] <= sign_q ? -$signed(div_rsp.quot[32:0])
						                       : $signed(div_rsp.quot[32:0]);
						if (comp_q == 2'd2) begin
							st_q <= S_START;
						end else begin
							comp_q <= comp_q + 2'd1;
							st_q <= S_SMUL;
						end
					end
				end
				S_START: begin
					stx_q[ch_q] <= negsat(sv_q[0]);
					sty_q[ch_q] <= negsat(sv_q[1]);
					stz_q[ch_q] <= negsat(sv_q[2]);
					nt_q[ch_q] <= '0;
					rdur_q[ch_q] <= dur_q;
					run_q[ch_q] <= 1'b1;
					st_q <= S_OUT0;
				end
				S_OUT0: begin
					if (!valid_ch) begin
						for (int k = 0; k < 3; k++) res_q[k] <= '0;
						st_q <= S_PUSH;
					end else begin
						st_q <= S_OUT1;
					end
				end
				S_OUT1: begin
					// gate on even floor(time * frequency)
					env_en_q <= run_q[ch_q] && !mul_q[32];
					ret_q <= S_OMUL;
					comp_q <= '0;
					st_q <= S_ENV;
				end
				S_OMUL: st_q <= S_OCAP;
				S_OCAP: begin
					res_q[comp_q] <= sat32(mul_q >>> 16);
					if (comp_q == 2'd2) begin
						st_q <= S_PUSH;
					end else begin
						comp_q <= comp_q + 2'd1;
						st_q <= S_OMUL;
					end
				end
				S_PUSH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						mdata_q <= {res_q[2], res_q[1], res_q[0]};
						muser_q <= {valid_ch && run_q[ch_q], player_q};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_one_request, accept, !s_tready, "request accepted while busy")
	`ASSERT_IMPLIES(a_div_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`ASSERT_IMPLIES(a_sqrt_idle, sqrt_req.start, !sqrt_rsp.busy, "root restarted while busy")
	`ASSERT_IMPLIES(a_run_in_range, run_q[0], nt_q[0] < ENV_TIME[ENVELOPE_POINTS-1],
		"running channel past envelope end")

endmodule

// File: rtl/seg_divider.sv
// restoring divider, 64-bit unsigned dividend by 32-bit divisor, one bit per cycle
// depends on seg_pkg
module seg_divider import seg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	always_comb begin
		sh = {rem_q, quo_q[63]};
		diff = sh - {1'b0, dsr_q};
		ge = sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// File: rtl/seg_sqrt.sv
// digit-by-digit integer square root of a 64-bit value, two radicand bits per cycle
// depends on seg_pkg
module seg_sqrt import seg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] sh;
	logic [34:0] trial;
	logic        ge;

	always_comb begin
		sh = {rem_q[32:0], rad_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
		ge = sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q <= req.radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			rem_q <= ge ? (sh - trial) : sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

// File: test/tb_top.sv
// testbench of shake_envelope_generator: random and directed requests on the stream port,
// with a scoreboard class that predicts each result from its own copy of the channel state
// depends on seg_pkg and the block's rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import seg_pkg::*;

	typedef struct {
		bit player;
		int sx;
		int sy;
		int sz;
		bit active;
	} shake_result_t;

	class shake_scoreboard;
		bit [30:0] regs [NUM_REGS];
		int vec_x [2], vec_y [2], vec_z [2];
		bit [16:0] ntime [2];
		bit [31:0] dur [2];
		bit run [2];
		shake_result_t pending [$];
		int errors;
		int results;

		function void clear_all();
			for (int c = 0; c < 2; c++) begin
				vec_x[c] = 0;
				vec_y[c] = 0;
				vec_z[c] = 0;
				ntime[c] = 0;
				dur[c] = 32'd65536;
				run[c] = 0;
			end
		endfunction

		function new();
			for (int i = 0; i < NUM_REGS; i++) regs[i] = CFG_RESET[i];
			clear_all();
		endfunction

		function int clip32(longint v);
			if (v > 64'sd2147483647) return 32'h7FFFFFFF;
			if (v < -64'sd2147483648) return 32'h80000000;
			return int'(v);
		endfunction

		function longint unsigned root64(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'h1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// piecewise-linear amplitude over normalized time
		function longint envelope(longint t);
			longint pt [5], pv [5];
			int i;
			pt = '{0, 6554, 19661, 32768, 65536};
			pv = '{65536, 45875, 32768, 26214, 0};
			if (t < 0 || t >= 65536) return 0;
			i = 0;
			while (i < 5 && t >= pt[i]) i++;
			if (i > 0) i--;
			if (i > 3) return pv[i];
			return pv[i] + ((pv[i+1] - pv[i]) * (t - pt[i])) / (pt[i+1] - pt[i]);
		endfunction

		function void begin_shake(int c, longint x, longint y, longint z, bit [31:0] d);
			vec_x[c] = clip32(-x);
			vec_y[c] = clip32(-y);
			vec_z[c] = clip32(-z);
			ntime[c] = 0;
			dur[c] = d;
			run[c] = 1;
		endfunction

		function longint blend(longint ratio, bit [30:0] lo, bit [30:0] hi);
			longint p;
			p = ratio * (longint'(hi) - longint'(lo));
			return longint'(lo) + (p >>> 16);
		endfunction

		function void accel_event(int c, int x, int y, int z);
			longint ax, ay, az, len, lo, hi, ratio, mag, d, cl;
			longint sx, sy, sz, amp;
			longint unsigned sq;
			ax = (longint'(x) * 45875) >>> 16;
			ay = (longint'(y) * 45875) >>> 16;
			az = z;
			sq = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
			len = longint'(root64(sq));
			lo = regs[REG_ACCEL_LOW];
			hi = regs[REG_ACCEL_HIGH];
			if (len < lo) return;
			if (hi <= lo) begin
				ratio = 65536;
			end else begin
				cl = len > hi ? hi : len;
				ratio = ((cl - lo) * 65536) / (hi - lo);
			end
			mag = blend(ratio, regs[REG_MAG_LOW], regs[REG_MAG_HIGH]);
			amp = run[c] ? envelope(ntime[c]) : 0;
			if (mag <= amp) return;
			d = blend(ratio, regs[REG_DUR_LOW], regs[REG_DUR_HIGH]);
			sx = 0;
			sy = 0;
			sz = 0;
			if (len > 0) begin
				sx = (ax * mag) / len;
				sy = (ay * mag) / len;
				sz = (az * mag) / len;
			end
			begin_shake(c, sx, sy, sz, d[31:0]);
		endfunction

		function void advance(bit [15:0] dt);
			longint unsigned q, s;
			for (int c = 0; c < 2; c++) begin
				if (!run[c]) continue;
				if (dur[c] == 0) q = 64'h1 << 40;
				else q = {32'b0, dt, 16'b0} / {32'b0, dur[c]};
				s = ntime[c] + q;
				ntime[c] = s > 64'h1FFFF ? 17'h1FFFF : s[16:0];
				if (ntime[c] >= 17'd65536) run[c] = 0;
			end
		endfunction

		function void note_request(bit [1:0] mode, bit c, bit [15:0] dt, int x, int y, int z);
			shake_result_t r;
			longint unsigned gate;
			longint amp;
			case (mode)
				MODE_TICK: advance(dt);
				MODE_CLEAR: clear_all();
				MODE_ACCEL: accel_event(c, x, y, z);
				default: begin_shake(c, x, y, z, {1'b0, regs[REG_FORCE_DUR]});
			endcase
			gate = ({47'b0, ntime[c]} * {33'b0, regs[REG_FREQ]}) >> 32;
			amp = (!gate[0] && run[c]) ? envelope(ntime[c]) : 0;
			r.player = c;
			r.sx = clip32((longint'(vec_x[c]) * amp) >>> 16);
			r.sy = clip32((longint'(vec_y[c]) * amp) >>> 16);
			r.sz = clip32((longint'(vec_z[c]) * amp) >>> 16);
			r.active = run[c];
			pending.push_back(r);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			errors++;
			$display("mismatch on result %0d: %s got %0d expected %0d", results, what, got,
				want);
		endtask

		task check_result(bit c, int x, int y, int z, bit act);
			shake_result_t e;
			results++;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result, player", c, -1);
				return;
			end
			e = pending.pop_front();
			if (c != e.player) report_mismatch("out_player", c, e.player);
			if (x != e.sx) report_mismatch("shake_x", x, e.sx);
			if (y != e.sy) report_mismatch("shake_y", y, e.sy);
			if (z != e.sz) report_mismatch("shake_z", z, e.sz);
			if (act != e.active) report_mismatch("active", act, e.active);
		endtask
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [111:0] s_tdata;  // delta_time, vec_x, vec_y, vec_z
	logic [2:0] s_tuser;    // mode, player
	logic m_tvalid, m_tready;
	logic [95:0] m_tdata;   // shake_x, shake_y, shake_z
	logic [1:0] m_tuser;    // out_player, active
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	shake_scoreboard sb = new();
	bit hold_req;
	bit quiet;
	int idle_cycles;
	int requests;

	shake_envelope_generator i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: short random stalls, rare long ones, one long hold-off on request
	initial begin
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end else if (quiet) begin
				m_tready <= 1;
			end else if ($urandom_range(0, 99) < 3) begin
				m_tready <= 0;
				repeat ($urandom_range(20, 150)) @(posedge clk);
			end else begin
				m_tready <= $urandom_range(0, 3) != 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tuser[1:0], s_tuser[2], s_tdata[15:0], s_tdata[47:16],
					s_tdata[79:48], s_tdata[111:80]);
				requests++;
			end
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
					m_tuser[1]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= 20000) begin
				$display("timeout with %0d results pending", sb.pending.size());
				$display("[shake_envelope_generator] ERROR");
				$finish;
			end
		end
	end

	task write_reg(logic [2:0] idx, bit [30:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		sb.regs[idx] = value;
	endtask

	task write_all(logic [30:0] v [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), v[i]);
	endtask

	task send_request(bit [1:0] mode, bit c, bit [15:0] dt, int x, int y, int z);
		int gap, r;
		r = $urandom_range(0, 99);
		gap = quiet ? 0 : r < 50 ? 0 : r < 92 ? $urandom_range(1, 3) : $urandom_range(20, 200);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= {c, mode};
		s_tdata <= {z, y, x, dt};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	function int rand_component();
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return int'($urandom_range(0, 80000000)) - 40000000;
		endcase
	endfunction

	task random_requests(int n);
		bit [1:0] mode;
		bit [15:0] dt;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			mode = r < 50 ? MODE_TICK : r < 78 ? MODE_ACCEL : r < 96 ? MODE_FORCE : MODE_CLEAR;
			dt = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6000));
			send_request(mode, $urandom_range(0, 1), dt, rand_component(), rand_component(),
				rand_component());
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// defaults: saturated negation, clamp at the high threshold, ignored event, envelope end
		send_request(MODE_TICK, 0, 16'd0, 0, 0, 0);
		send_request(MODE_FORCE, 0, 16'd0, 32'h80000000, 32'h7FFFFFFF, 0);
		send_request(MODE_TICK, 0, 16'd1000, 0, 0, 0);
		send_request(MODE_ACCEL, 1, 16'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_request(MODE_ACCEL, 0, 16'd0, 1, 1, 1);
		send_request(MODE_ACCEL, 0, 16'd0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(MODE_TICK, 1, 16'd3000, 0, 0, 0);
		send_request(MODE_TICK, 0, 16'hFFFF, 0, 0, 0);
		send_request(MODE_FORCE, 1, 16'd0, -5000000, 7000000, -3000000);
		send_request(MODE_CLEAR, 1, 16'hFFFF, -1, -1, -1);
		send_request(MODE_TICK, 1, 16'd100, 0, 0, 0);
		drain();

		// equal thresholds, zero low threshold, zero forced duration, top frequency
		write_all('{31'd0, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd0, 31'd1, 31'd0,
			31'h7FFFFFFF});
		send_request(MODE_ACCEL, 0, 16'd0, 0, 0, 0);
		send_request(MODE_TICK, 0, 16'd1, 0, 0, 0);
		send_request(MODE_FORCE, 1, 16'd0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(MODE_TICK, 1, 16'd0, 0, 0, 0);
		send_request(MODE_ACCEL, 1, 16'd0, 32'h80000000, 12345, 32'h7FFFFFFF);
		send_request(MODE_TICK, 1, 16'd2, 0, 0, 0);
		drain();

		write_all(CFG_RESET);
		hold_req = 1;
		random_requests(120);
		drain();

		write_all('{31'd0, 31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF, 31'd1,
			31'd0});
		random_requests(60);
		drain();

		write_all('{31'd655360, 31'd52428800, 31'd65536, 31'd2000, 31'd65536, 31'd6000,
			31'd20000, 31'd1500000});
		quiet = 1;
		random_requests(40);
		quiet = 0;
		random_requests(60);
		drain();

		write_all('{31'h7FFFFFFF, 31'd1000, 31'd100000, 31'd70000, 31'd3000, 31'd9000,
			31'h7FFFFFFF, 31'd5});
		random_requests(40);
		drain();

		write_all(CFG_RESET);
		random_requests(60);
		drain();

		$display("covered %0d requests and %0d results over six register settings,",
			requests, sb.results);
		$display("including a long receiver hold-off; %0d mismatches", sb.errors);
		if (sb.errors == 0) begin
			$display("[shake_envelope_generator] OK");
		end else begin
			$display("[shake_envelope_generator] ERROR");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/seg_pkg.sv
rtl/seg_divider.sv
rtl/seg_sqrt.sv
rtl/shake_envelope_generator.sv
test/tb_top.sv
